### design/mfsgd_pkg.sv
//------------------------------------------------------------------------------
// mfsgd_pkg
// Shared constants and arithmetic helpers for the SGD factor block.
//------------------------------------------------------------------------------
`default_nettype none

package mfsgd_pkg;

    localparam int RANK     = 16;
    localparam int NUM_ROWS = 1024;
    localparam int NUM_COLS = 1024;

    localparam int EW   = (RANK > 1) ? $clog2(RANK) : 1;
    localparam int RW   = 10;
    localparam int CW   = 10;
    localparam int AW   = RW + ((RANK > 1) ? $clog2(RANK) : 0);
    localparam int MEMD = NUM_ROWS * RANK;
    localparam int CMEMD = NUM_COLS * RANK;

    localparam logic [2:0] OP_TRAIN = 3'd0;
    localparam logic [2:0] OP_WR_ROW = 3'd1;
    localparam logic [2:0] OP_WR_COL = 3'd2;
    localparam logic [2:0] OP_RD_ROW = 3'd3;
    localparam logic [2:0] OP_RD_COL = 3'd4;

    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_ABOVE = 2'd1;
    localparam logic [1:0] DIR_BELOW = 2'd2;

    localparam logic [0:0] CFG_LEARN_RATE = 1'b0;
    localparam logic [0:0] CFG_REG_WEIGHT = 1'b1;

    localparam logic [23:0] LR_RESET = 24'd369098;
    localparam logic [23:0] RW_RESET = 24'd1677722;

    // accumulator: 64-bit products summed RANK times
    localparam int ACCW = 64 + 7;

    function automatic logic signed [31:0] sat32(input logic signed [ACCW-1:0] v);
        logic signed [31:0] r;
        if (v > ACCW'(signed'(32'sh7fffffff)))       r = 32'sh7fffffff;
        else if (v < ACCW'(signed'(-32'sh80000000))) r = -32'sh80000000;
        else                                         r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

### design/mfsgd_mem.sv
//------------------------------------------------------------------------------
// mfsgd_mem
// Single-port synchronous factor memory, registered read.
//------------------------------------------------------------------------------
`default_nettype none

module mfsgd_mem #(
    parameter int DEPTH = 16384,
    parameter int ADDR_W = 14
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [31:0]       i_wdata,
    output logic [31:0]            o_rdata
);
    logic [31:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

`default_nettype wire

### design/mfsgd_upd.sv
//------------------------------------------------------------------------------
// mfsgd_upd
// Two-stage element update: new = sat(a - rnd(lr*(s*b + rnd(lambda*a)))).
//------------------------------------------------------------------------------
`default_nettype none

module mfsgd_upd (
    input  wire logic               i_clk,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    input  wire logic               i_neg,
    input  wire logic [23:0]        i_lr,
    input  wire logic [23:0]        i_lambda,
    output logic signed [31:0]      o_new
);
    import mfsgd_pkg::*;

    logic signed [56:0] w_r_prod;
    logic signed [33:0] w_r;
    logic signed [34:0] n_g;
    logic signed [34:0] r_g;
    logic signed [31:0] r_a1;
    logic signed [31:0] r_a2;
    logic signed [59:0] r_d_prod;
    logic signed [36:0] w_delta;
    logic signed [ACCW-1:0] w_diff;

    assign w_r_prod = $signed({1'b0, i_lambda}) * i_a;
    assign w_r = 34'((w_r_prod + 57'sd8388608) >>> 24);
    assign n_g = i_neg ? (35'(w_r) - 35'(i_b)) : (35'(w_r) + 35'(i_b));

    always_ff @(posedge i_clk) begin
        r_g  <= n_g;
        r_a1 <= i_a;
        r_d_prod <= $signed({1'b0, i_lr}) * r_g;
        r_a2 <= r_a1;
    end

    assign w_delta = 37'((r_d_prod + 60'sd8388608) >>> 24);
    assign w_diff  = ACCW'(r_a2) - ACCW'(w_delta);
    assign o_new   = sat32(w_diff);
endmodule

`default_nettype wire

### design/matrix_factor_sgd_abs_loss.sv
//------------------------------------------------------------------------------
// matrix_factor_sgd_abs_loss
// SGD matrix factorization step under absolute loss with L2 weight decay.
//------------------------------------------------------------------------------
// Usage: items arrive on the i_valid/o_ready channel and each produces exactly
// one result on o_valid/i_ready. Opcodes write or read one factor element or
// run a training step on a row/column vector pair held in two single-port
// memories (row and column, RANK elements per vector).
// A write or read item passes through the RDWR, RDWT and OUT states before its
// result shows. A train item reads both vectors element by element, one
// multiply per cycle for the dot product, then updates the row vector and then
// the column vector, each element read, passed through the two-stage update
// unit and written back, or shows its result with no update. The single memory
// port of each store and the serial update make the work go element by element.
// One item is worked at a time; a new item is taken once the previous result
// has left the output register, at the earliest in the cycle of its transfer.
// Config writes (index 0 learn rate, 1 lambda) are taken at any time and must
// be issued only while idle.
// Reset restores the learn rate and lambda; the memories are not cleared and
// must be loaded before training. A stalled receiver holds the result in place.
//------------------------------------------------------------------------------
`default_nettype none

module matrix_factor_sgd_abs_loss (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [2:0]         i_opcode,
    input  wire logic [9:0]         i_row_index,
    input  wire logic [9:0]         i_col_index,
    input  wire logic [3:0]         i_elem_index,
    input  wire logic signed [31:0] i_data_value,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_prediction,
    output logic [1:0]              o_direction,
    output logic signed [31:0]      o_read_value,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [0:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data
);
    import mfsgd_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_RDWR = 8'b00000010,
        S_DOT  = 8'b00000100,
        S_DIR  = 8'b00001000,
        S_UPX  = 8'b00010000,
        S_UPY  = 8'b00100000,
        S_RDWT = 8'b01000000,
        S_OUT  = 8'b10000000
    } t_state;

    t_state r_state;
    logic [23:0] r_lr, r_lambda;
    logic [2:0]  r_op;
    logic [9:0]  r_ri, r_ci;
    logic [3:0]  r_ei;
    logic signed [31:0] r_dv;
    logic [EW:0] r_k;
    logic [2:0]  r_ph;
    logic signed [ACCW-1:0] r_acc;
    logic signed [63:0] r_prod;
    logic        r_neg;
    logic signed [31:0] r_xa, r_yb, r_wval;
    logic        r_row_we, r_col_we;
    logic [AW-1:0] r_row_wa, r_col_wa;

    logic [AW-1:0] w_row_addr, w_col_addr;
    logic signed [31:0] w_row_q, w_col_q, w_new;
    logic w_row_ok, w_col_ok, w_ei_ok;

    // take a new item in the cycle the waiting result transfers
    assign o_ready     = (r_state == S_IDLE) && (!o_valid || i_ready);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr     <= LR_RESET;
            r_lambda <= RW_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LEARN_RATE: r_lr     <= i_cfg_data;
                CFG_REG_WEIGHT: r_lambda <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_row_ok = 32'(r_ri) < NUM_ROWS;
    assign w_col_ok = 32'(r_ci) < NUM_COLS;
    assign w_ei_ok  = 32'(r_ei) < RANK;

    // element address of the current sweep or of the read/write item, or the write-back address
    always_comb begin
        w_row_addr = AW'(32'(r_ri) * RANK + 32'(r_k[EW-1:0]));
        w_col_addr = AW'(32'(r_ci) * RANK + 32'(r_k[EW-1:0]));
        if (r_state == S_RDWR) begin
            w_row_addr = AW'(32'(r_ri) * RANK + 32'(r_ei));
            w_col_addr = AW'(32'(r_ci) * RANK + 32'(r_ei));
        end
        if (r_row_we) w_row_addr = r_row_wa;
        if (r_col_we) w_col_addr = r_col_wa;
    end

    mfsgd_mem #(.DEPTH(MEMD), .ADDR_W(AW)) u_row (
        .i_clk(i_clk), .i_we(r_row_we), .i_addr(w_row_addr),
        .i_wdata(r_wval), .o_rdata(w_row_q));
    mfsgd_mem #(.DEPTH(CMEMD), .ADDR_W(AW)) u_col (
        .i_clk(i_clk), .i_we(r_col_we), .i_addr(w_col_addr),
        .i_wdata(r_wval), .o_rdata(w_col_q));

    mfsgd_upd u_upd (
        .i_clk(i_clk), .i_a(r_xa), .i_b(r_yb), .i_neg(r_neg),
        .i_lr(r_lr), .i_lambda(r_lambda), .o_new(w_new));

    // per-element phases for the update sweeps:
    // 0 issue read or prior write-back, 1 issue read, 2 latch a/b, 3,4 update pipe, 5 write back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_valid  <= 1'b0;
            r_row_we <= 1'b0;
            r_col_we <= 1'b0;
            r_k      <= '0;
            r_ph     <= '0;
        end else begin
            r_row_we <= 1'b0;
            r_col_we <= 1'b0;
            if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_op <= i_opcode; r_ri <= i_row_index; r_ci <= i_col_index;
                        r_ei <= i_elem_index; r_dv <= i_data_value;
                        r_k <= '0; r_ph <= '0; r_acc <= '0;
                        o_prediction <= '0; o_direction <= DIR_NONE;
                        o_read_value <= '0;
                        r_state <= (i_opcode == OP_TRAIN) ? S_DOT : S_RDWR;
                    end
                end
                S_RDWR: begin
                    // address applied this cycle; data next
                    r_row_wa <= w_row_addr; r_col_wa <= w_col_addr;
                    r_wval   <= r_dv;
                    if (w_ei_ok) begin
                        r_row_we <= (r_op == OP_WR_ROW) && w_row_ok;
                        r_col_we <= (r_op == OP_WR_COL) && w_col_ok;
                    end
                    r_state <= S_RDWT;
                end
                S_RDWT: begin
                    if (w_ei_ok && r_op == OP_RD_ROW && w_row_ok) o_read_value <= w_row_q;
                    if (w_ei_ok && r_op == OP_RD_COL && w_col_ok) o_read_value <= w_col_q;
                    r_state <= S_OUT;
                end
                S_DOT: begin
                    if (!(w_row_ok && w_col_ok)) begin
                        r_state <= S_OUT;
                    end else begin
                        // pipeline: read k, multiply k-1, accumulate k-2
                        if (r_k >= (EW+1)'(1) && r_k <= (EW+1)'(RANK))
                            r_prod <= w_row_q * w_col_q;
                        if (r_k >= (EW+1)'(2))
                            r_acc <= r_acc + ACCW'(r_prod);
                        if (r_k == (EW+1)'(RANK + 1)) begin
                            r_state <= S_DIR;
                        end
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DIR: begin
                    o_prediction <= sat32((r_acc >>> 24));
                    r_k <= '0; r_ph <= '0;
                    if (ACCW'(r_dv) > (r_acc >>> 24)) begin
                        o_direction <= DIR_ABOVE; r_neg <= 1'b1; r_state <= S_UPX;
                    end else if (ACCW'(r_dv) < (r_acc >>> 24) || r_acc[23:0] != '0) begin
                        o_direction <= DIR_BELOW; r_neg <= 1'b0; r_state <= S_UPX;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_UPX, S_UPY: begin
                    r_ph <= r_ph + 1'b1;
                    if (r_ph == 3'd2) begin
                        r_xa <= (r_state == S_UPX) ? w_row_q : w_col_q;
                        r_yb <= (r_state == S_UPX) ? w_col_q : w_row_q;
                    end
                    if (r_ph == 3'd5) begin
                        r_wval <= w_new;
                        r_row_wa <= w_row_addr; r_col_wa <= w_col_addr;
                        r_row_we <= (r_state == S_UPX);
                        r_col_we <= (r_state == S_UPY);
                        r_ph <= '0;
                        if (r_k == (EW+1)'(RANK - 1)) begin
                            r_k <= '0;
                            r_state <= (r_state == S_UPX) ? S_UPY : S_OUT;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_row_we && !r_col_we) begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_row_we && r_col_we)) else $error("both memories written at once");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_IDLE) else $error("result shown while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_direction != DIR_NONE) |-> r_op == OP_TRAIN)
        else $error("direction on non-train item");
endmodule

`default_nettype wire
